@@ hw/rtl/mtle_pkg.sv @@
// ----------------------------------------------------------------------------
// mtle_pkg
// Shared codes, types and constants for the timer list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mtle_pkg;

  // Request action codes
  localparam logic [2:0] ACT_LOAD  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_STOP  = 3'd2;
  localparam logic [2:0] ACT_TICK  = 3'd3;
  localparam logic [2:0] ACT_POLL  = 3'd4;

  // Poll reports at most this many expiries
  localparam int unsigned MAX_RESULTS = 8;
  localparam int          FCNT_W      = 4;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_STOP,
    CELL_INSERT,
    CELL_ROTATE
  } cell_op_t;

  // Broadcast control bundle
  typedef struct packed {
    cell_op_t    op;
    logic [2:0]  tidx;
    logic [31:0] load_dl;
    logic [31:0] load_rl;
  } cell_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/mtle_cell.sv @@
// ----------------------------------------------------------------------------
// mtle_cell
// One slot of the timer chain: holds a timer's index, active flag, deadline
// and reload value. Chain order, head first, is the recency order of the
// active timers.
// ----------------------------------------------------------------------------
`default_nettype none

module mtle_cell #(
  parameter int IDX_W   = 3,
  parameter int CELL_ID = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mtle_pkg::cell_ctrl_t    ctrl,
  // neighbor toward the head (or the insert data for the head cell)
  input  logic                    up_active,
  input  logic [IDX_W-1:0]        up_idx,
  input  logic [31:0]             up_dl,
  input  logic [31:0]             up_rl,
  // neighbor toward the tail (or the updated head for the tail cell)
  input  logic                    dn_active,
  input  logic [IDX_W-1:0]        dn_idx,
  input  logic [31:0]             dn_dl,
  input  logic [31:0]             dn_rl,
  input  logic                    found_in,
  output logic                    found_out,
  output logic                    hit,
  output logic                    active,
  output logic [IDX_W-1:0]        idx,
  output logic [31:0]             dl,
  output logic [31:0]             rl
);
  import mtle_pkg::*;

  logic               active_r, active_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [31:0]        dl_r, dl_nxt;
  logic [31:0]        rl_r, rl_nxt;

  // Index match and the match-at-or-below chain (drives insert shifting)
  always_comb begin
    hit       = (idx_r == IDX_W'(ctrl.tidx));
    found_out = hit | found_in;
  end

  // Next slot contents
  always_comb begin
    active_nxt = active_r;
    idx_nxt    = idx_r;
    dl_nxt     = dl_r;
    rl_nxt     = rl_r;
    case (ctrl.op)
      CELL_LOAD: begin
        if (hit) begin
          dl_nxt = ctrl.load_dl;
          rl_nxt = ctrl.load_rl;
        end
      end
      CELL_STOP: begin
        if (hit) active_nxt = 1'b0;
      end
      CELL_INSERT: begin
        // slots from the head down to the started timer move one step down
        if (found_out) begin
          active_nxt = up_active;
          idx_nxt    = up_idx;
          dl_nxt     = up_dl;
          rl_nxt     = up_rl;
        end
      end
      CELL_ROTATE: begin
        active_nxt = dn_active;
        idx_nxt    = dn_idx;
        dl_nxt     = dn_dl;
        rl_nxt     = dn_rl;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      idx_r    <= IDX_W'(CELL_ID);
      dl_r     <= '0;
      rl_r     <= '0;
    end else begin
      active_r <= active_nxt;
      idx_r    <= idx_nxt;
      dl_r     <= dl_nxt;
      rl_r     <= rl_nxt;
    end
  end

  assign active = active_r;
  assign idx    = idx_r;
  assign dl     = dl_r;
  assign rl     = rl_r;

endmodule

`default_nettype wire

@@ hw/rtl/multi_timer_list_engine.sv @@
// ----------------------------------------------------------------------------
// multi_timer_list_engine
// Table of NUM_TIMERS software timers with a 32-bit tick count.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on in_* (valid/ready): load, start, stop, tick, poll.
//    Results leave on out_* (valid/ready); out_last marks a request's final
//    result.
//  - Load, start, stop, tick and undefined actions give one result,
//    registered in the output stage the cycle after acceptance.
//  - Poll is accepted, then rotates every timer of the chain once through
//    its head in the scan state and closes in the finish state, which
//    registers the final result. Each expired timer (up to 8) yields one
//    result; a poll that finds nothing yields one result with out_fired low.
//  - The head compare/add unit checks one timer per cycle while the scan
//    is not held; that sets the poll length.
//  - A request is taken only while idle and the output stage is free or
//    being drained, so one result may wait while the next request enters.
//  - When the receiver stalls, the poll scan holds at the timer that would
//    need the output stage; nothing is dropped.
//  - Reset clears the tick count, all deadlines and reloads, and all
//    active flags; the first request can be taken in the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_list_engine #(
  parameter int NUM_TIMERS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [2:0]  in_timer_index,
  input  logic [31:0] in_delay,
  input  logic [31:0] in_reload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic        out_fired,
  output logic [2:0]  out_fired_index,
  output logic        out_last
);
  import mtle_pkg::*;

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam logic [IDX_W-1:0] CNT_LAST = IDX_W'(NUM_TIMERS - 1);

  // Controller registers
  state_t              state_r, state_nxt;
  logic [31:0]         tick_r, tick_nxt;
  logic [IDX_W-1:0]    cnt_r, cnt_nxt;
  logic [FCNT_W-1:0]   fcnt_r, fcnt_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [2:0]          pend_idx_r, pend_idx_nxt;

  // Output stage
  logic                out_valid_r, out_valid_nxt;
  logic                out_status_r, out_fired_r, out_last_r;
  logic [2:0]          out_idx_r;

  // Result push
  logic                push;
  logic                p_status, p_fired, p_last;
  logic [2:0]          p_idx;

  // Chain signals
  cell_ctrl_t              ctrl;
  logic [NUM_TIMERS-1:0]   c_active;
  logic [NUM_TIMERS-1:0]   c_hit;
  logic [NUM_TIMERS-1:0]   c_found;
  logic [IDX_W-1:0]        c_idx [NUM_TIMERS];
  logic [31:0]             c_dl  [NUM_TIMERS];
  logic [31:0]             c_rl  [NUM_TIMERS];

  logic [31:0]             mv_dl, mv_rl;
  logic                    h_fire, h_emit, h_active_upd;
  logic [31:0]             h_dl_upd;

  logic can_push, in_fire, idx_ok, already, step_ok;

  assign can_push = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_IDLE) && can_push;
  assign in_fire  = in_valid && in_ready;
  assign idx_ok   = ({29'd0, in_timer_index} < 32'(NUM_TIMERS));
  assign already  = |(c_hit & c_active);

  // Select the started timer's data for insertion at the head
  always_comb begin
    mv_dl = '0;
    mv_rl = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (c_hit[i]) begin
        mv_dl = mv_dl | c_dl[i];
        mv_rl = mv_rl | c_rl[i];
      end
    end
  end

  // Head check during poll: expiry compare and rearm
  always_comb begin
    h_fire       = c_active[0] && (tick_r >= c_dl[0]);
    h_emit       = h_fire && (fcnt_r < FCNT_W'(MAX_RESULTS));
    h_active_upd = (h_fire && (c_rl[0] == 32'd0)) ? 1'b0 : c_active[0];
    h_dl_upd     = (h_fire && (c_rl[0] != 32'd0)) ? (tick_r + c_rl[0]) : c_dl[0];
  end

  // Scan holds when a new expiry needs the busy output stage
  assign step_ok = !(h_emit && pend_valid_r && !can_push);

  // Timer chain
  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    logic             up_active, dn_active, found_in;
    logic [IDX_W-1:0] up_idx, dn_idx;
    logic [31:0]      up_dl, up_rl, dn_dl, dn_rl;

    if (i == 0) begin : g_head
      assign up_active = 1'b1;
      assign up_idx    = IDX_W'(in_timer_index);
      assign up_dl     = mv_dl;
      assign up_rl     = mv_rl;
    end else begin : g_mid_up
      assign up_active = c_active[i-1];
      assign up_idx    = c_idx[i-1];
      assign up_dl     = c_dl[i-1];
      assign up_rl     = c_rl[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign dn_active = h_active_upd;
      assign dn_idx    = c_idx[0];
      assign dn_dl     = h_dl_upd;
      assign dn_rl     = c_rl[0];
      assign found_in  = 1'b0;
    end else begin : g_mid_dn
      assign dn_active = c_active[i+1];
      assign dn_idx    = c_idx[i+1];
      assign dn_dl     = c_dl[i+1];
      assign dn_rl     = c_rl[i+1];
      assign found_in  = c_found[i+1];
    end

    mtle_cell #(
      .IDX_W   (IDX_W),
      .CELL_ID (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .up_active (up_active),
      .up_idx    (up_idx),
      .up_dl     (up_dl),
      .up_rl     (up_rl),
      .dn_active (dn_active),
      .dn_idx    (dn_idx),
      .dn_dl     (dn_dl),
      .dn_rl     (dn_rl),
      .found_in  (found_in),
      .found_out (c_found[i]),
      .hit       (c_hit[i]),
      .active    (c_active[i]),
      .idx       (c_idx[i]),
      .dl        (c_dl[i]),
      .rl        (c_rl[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_action == ACT_POLL)) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (step_ok && (cnt_r == CNT_LAST)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (can_push) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath control and result generation
  always_comb begin
    ctrl.op        = CELL_HOLD;
    ctrl.tidx      = in_timer_index;
    ctrl.load_dl   = tick_r + in_delay;
    ctrl.load_rl   = in_reload;
    push           = 1'b0;
    p_status       = 1'b0;
    p_fired        = 1'b0;
    p_idx          = 3'd0;
    p_last         = 1'b0;
    tick_nxt       = tick_r;
    cnt_nxt        = cnt_r;
    fcnt_nxt       = fcnt_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_action == ACT_POLL) begin
            cnt_nxt        = '0;
            fcnt_nxt       = '0;
            pend_valid_nxt = 1'b0;
          end else begin
            push   = 1'b1;
            p_last = 1'b1;
            case (in_action)
              ACT_LOAD: begin
                if (idx_ok) ctrl.op = CELL_LOAD;
              end
              ACT_START: begin
                if (idx_ok) begin
                  if (already) p_status = 1'b1;
                  else         ctrl.op  = CELL_INSERT;
                end
              end
              ACT_STOP: begin
                if (idx_ok) ctrl.op = CELL_STOP;
              end
              ACT_TICK: tick_nxt = tick_r + 32'd1;
              default: begin
              end
            endcase
          end
        end
      end
      ST_SCAN: begin
        if (step_ok) begin
          ctrl.op = CELL_ROTATE;
          cnt_nxt = cnt_r + 1'b1;
          if (h_emit) begin
            // previous expiry is now known not to be the last one
            fcnt_nxt       = fcnt_r + 1'b1;
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = 3'(c_idx[0]);
            if (pend_valid_r) begin
              push    = 1'b1;
              p_fired = 1'b1;
              p_idx   = pend_idx_r;
            end
          end
        end
      end
      ST_FINISH: begin
        if (can_push) begin
          push           = 1'b1;
          p_last         = 1'b1;
          p_fired        = pend_valid_r;
          p_idx          = pend_valid_r ? pend_idx_r : 3'd0;
          pend_valid_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (push)           out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      tick_r       <= '0;
      cnt_r        <= '0;
      fcnt_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      tick_r       <= tick_nxt;
      cnt_r        <= cnt_nxt;
      fcnt_r       <= fcnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    if (push) begin
      out_status_r <= p_status;
      out_fired_r  <= p_fired;
      out_idx_r    <= p_idx;
      out_last_r   <= p_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_fired       = out_fired_r;
  assign out_fired_index = out_idx_r;
  assign out_last        = out_last_r;

  // Checks
  a_fcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= FCNT_W'(MAX_RESULTS))
    else $error("expiry count beyond result limit");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(c_hit))
    else $error("timer index held by more than one cell");

  a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("request taken during poll");

  a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !pend_valid_r)
    else $error("pending expiry left after poll");

  a_finish_push: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && can_push) |=> (out_valid_r && out_last_r))
    else $error("poll closed without final result");

endmodule

`default_nettype wire
